### sv/kbd_pkg.sv
// ----------------------------------------------------------------------------
// kbd_pkg: shared types, scan codes and key maps
// Scan set 1 codes, translation tables and the command word that the
// classifier hands to the character store.
// ----------------------------------------------------------------------------
package kbd_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 1024;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
    localparam int CHAR_W             = 7;

    // scan set 1 bytes
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_CAPS_BRK   = 8'hBA;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_ALT        = 8'h38;
    localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
    localparam logic [7:0] SC_ESCAPE     = 8'hE0;
    localparam logic [7:0] MAP_LAST      = 8'h53;
    localparam logic [7:0] EMPTY_CHAR    = 8'hFF;

    // command kinds
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic              ctrl;
        logic              alt;
    } cmd_t;

    localparam logic [CHAR_W-1:0] MAP_LO [0:83] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h23, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E
    };

    localparam logic [CHAR_W-1:0] MAP_HI [0:83] = '{
        7'h00, 7'h1B, 7'h21, 7'h22, 7'h3F, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h40, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E
    };

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 7'h61) && (c <= 7'h7A)) || ((c >= 7'h41) && (c <= 7'h5A));
    endfunction

    // zero means the make code yields no character
    function automatic logic [CHAR_W-1:0] map_char(input logic [7:0] code,
                                                   input logic       shift,
                                                   input logic       caps);
        logic [6:0]        idx;
        logic [CHAR_W-1:0] lo;
        logic [CHAR_W-1:0] hi;
        logic [CHAR_W-1:0] c;
        idx = (code <= MAP_LAST) ? code[6:0] : 7'd0;
        lo  = MAP_LO[idx];
        hi  = MAP_HI[idx];
        if ((code > MAP_LAST) || (lo == '0)) begin
            c = '0;
        end else if (caps) begin
            c = shift ? lo : hi;
            if (!is_letter(c)) begin
                c = shift ? hi : lo;
            end
        end else begin
            c = shift ? hi : lo;
        end
        return c;
    endfunction

endpackage

### sv/kbd_front.sv
// ----------------------------------------------------------------------------
// kbd_front: scan byte classifier
// Tracks modifier and escape state and turns each beat into a command.
// ----------------------------------------------------------------------------
module kbd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_read,
    input  logic [7:0]    in_code,
    input  logic          in_ready,
    output kbd_pkg::cmd_t cmd
);

    logic escape_reg, escape_next;
    logic caps_reg, caps_next;
    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic [kbd_pkg::CHAR_W-1:0] ch;

    always_comb begin
        escape_next = escape_reg;
        caps_next   = caps_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        cmd.kind    = kbd_pkg::CMD_NONE;
        cmd.ch      = '0;
        ch          = kbd_pkg::map_char(in_code, shift_reg, caps_reg);
        if (in_read) begin
            cmd.kind = kbd_pkg::CMD_READ;
        end else begin
            unique case (in_code) inside
                kbd_pkg::SC_LSHIFT, kbd_pkg::SC_RSHIFT:         shift_next = 1'b1;
                kbd_pkg::SC_LSHIFT_BRK, kbd_pkg::SC_RSHIFT_BRK: shift_next = 1'b0;
                kbd_pkg::SC_CAPS:     caps_next   = 1'b1;
                kbd_pkg::SC_CAPS_BRK: caps_next   = 1'b0;
                kbd_pkg::SC_CTRL:     ctrl_next   = 1'b1;
                kbd_pkg::SC_CTRL_BRK: ctrl_next   = 1'b0;
                kbd_pkg::SC_ALT:      alt_next    = 1'b1;
                kbd_pkg::SC_ALT_BRK:  alt_next    = 1'b0;
                kbd_pkg::SC_ESCAPE:   escape_next = 1'b1;
                default: begin
                    // make codes only; other break codes fall through untouched
                    if (!in_code[7]) begin
                        if (!escape_reg && (ch != '0)) begin
                            cmd.kind = kbd_pkg::CMD_WRITE;
                            cmd.ch   = ch;
                        end
                        escape_next = 1'b0;
                    end
                end
            endcase
        end
        cmd.ctrl = ctrl_next;
        cmd.alt  = alt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= 1'b0;
            caps_reg   <= 1'b0;
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
        end else if (in_valid && in_ready) begin
            escape_reg <= escape_next;
            caps_reg   <= caps_next;
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
        end
    end

endmodule

### sv/kbd_cmd_queue.sv
// ----------------------------------------------------------------------------
// kbd_cmd_queue: short command queue
// Small register queue that decouples the classifier from the store.
// ----------------------------------------------------------------------------
module kbd_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  kbd_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output kbd_pkg::cmd_t pop_cmd
);

    kbd_pkg::cmd_t                entry_reg [kbd_pkg::QUEUE_DEPTH];
    logic [kbd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [kbd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kbd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         push, pop;

    localparam logic [kbd_pkg::QPTR_W-1:0] LAST = kbd_pkg::QPTR_W'(kbd_pkg::QUEUE_DEPTH - 1);

    assign push_ready = (count_reg != kbd_pkg::QCNT_W'(kbd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/kbd_back.sv
// ----------------------------------------------------------------------------
// kbd_back: character ring and result register
// Executes commands against the character ring and holds one result beat.
// ----------------------------------------------------------------------------
module kbd_back #(
    parameter int FIFO_DEPTH = kbd_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  kbd_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_char_valid,
    output logic          out_char_stored,
    output logic          out_beep,
    output logic          out_ctrl,
    output logic          out_alt
);

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(FIFO_DEPTH);

    logic [kbd_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
    logic [kbd_pkg::CHAR_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;

    logic is_read_reg, got_reg, stored_reg, beep_reg, ctrl_reg, alt_reg;
    logic got_next, stored_next, beep_next;
    logic advance, do_write, do_read;

    assign advance   = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_ready = !out_valid_reg || out_ready;

    always_comb begin
        do_write       = 1'b0;
        do_read        = 1'b0;
        got_next       = 1'b0;
        stored_next    = 1'b0;
        beep_next      = 1'b0;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance) begin
            out_valid_next = 1'b1;
            unique case (cmd.kind)
                kbd_pkg::CMD_READ: begin
                    if (fill_reg != '0) begin
                        do_read     = 1'b1;
                        got_next    = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
                        fill_next   = fill_reg - 1'b1;
                    end
                end
                kbd_pkg::CMD_WRITE: begin
                    if (fill_reg == FULL) begin
                        beep_next = 1'b1;
                    end else begin
                        do_write    = 1'b1;
                        stored_next = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
                        fill_next   = fill_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a command moves into the output slot
    always_ff @(posedge aclk) begin
        if (advance) begin
            is_read_reg <= (cmd.kind == kbd_pkg::CMD_READ);
            got_reg     <= got_next;
            stored_reg  <= stored_next;
            beep_reg    <= beep_next;
            ctrl_reg    <= cmd.ctrl;
            alt_reg     <= cmd.alt;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_ptr_reg] <= cmd.ch;
        end
        if (do_read) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_char        = !is_read_reg ? 8'h00 :
                             got_reg      ? {1'b0, rd_data_reg} : kbd_pkg::EMPTY_CHAR;
    assign out_char_valid  = got_reg;
    assign out_char_stored = stored_reg;
    assign out_beep        = beep_reg;
    assign out_ctrl        = ctrl_reg;
    assign out_alt         = alt_reg;

endmodule

### sv/keyboard_scancode_to_ascii_fifo.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_to_ascii_fifo: scan set 1 translator with character ring
// Turns keyboard scan bytes into characters, buffers them and serves reads.
// ----------------------------------------------------------------------------
// usage
//   input stream: s_tuser = 0 carries a scan set 1 byte in s_tdata,
//   s_tuser = 1 is a read request (s_tdata is then ignored)
//   every input beat gives exactly one result beat on the m_ side
//   result: char_out, char_valid, char_stored, beep, ctrl_down, alt_down
//   a read with nothing buffered returns 255 with char_valid low
//   a character that finds the ring full is dropped and beep is raised
// timing
//   a result passes through the command queue and the output beat register; one beat per
//   cycle sustained while m_tready stays high, each command making one pass over the ring
//   a four-entry command queue separates the classifier from the ring,
//   so a stalled receiver backs up into the queue before s_tready drops
// reset
//   aresetn clears modifiers, escape flag, queue and ring pointers;
//   ring contents are not cleared and the output beat is dropped
// ----------------------------------------------------------------------------
module keyboard_scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = kbd_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_code
    input  logic        s_tuser,   // [0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] char_out, [8] char_valid, [9] char_stored,
                                   // [10] beep, [11] ctrl_down, [12] alt_down, [15:13] zero
);

    kbd_pkg::cmd_t front_cmd;
    kbd_pkg::cmd_t queue_cmd;
    logic          queue_valid;
    logic          queue_ready;

    logic [7:0] char_out;
    logic       char_valid, char_stored, beep, ctrl_down, alt_down;

    // classifier: modifier and escape tracking, key map lookup
    kbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_read  (s_tuser),
        .in_code  (s_tdata),
        .in_ready (s_tready),
        .cmd      (front_cmd)
    );

    // the input side is held off only by a full command queue
    kbd_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    // ring buffer and output beat register
    kbd_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (queue_valid),
        .cmd_ready       (queue_ready),
        .cmd             (queue_cmd),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_char        (char_out),
        .out_char_valid  (char_valid),
        .out_char_stored (char_stored),
        .out_beep        (beep),
        .out_ctrl        (ctrl_down),
        .out_alt         (alt_down)
    );

    assign m_tdata = {3'b000, alt_down, ctrl_down, beep, char_stored, char_valid, char_out};

    // a beat reports at most one of: character read, character stored, drop
    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(m_tdata[10:8]) <= 1))
        else $error("more than one outcome flag in a result beat");

    // a returned character is a nonzero 7-bit code
    a_read_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (!m_tdata[7] && (m_tdata[6:0] != 7'd0)))
        else $error("read returned an empty or 8-bit character");

    // scan beats carry a zero character, failed reads the empty code
    a_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> ((m_tdata[7:0] == 8'h00) || (m_tdata[7:0] == 8'hFF)))
        else $error("unexpected character code without a read");

    // after a reset cycle neither a result beat nor a queued command is offered
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !queue_valid))
        else $error("result or queued command survived reset");

endmodule
